// ===== src/sfx_pkg.sv =====
package sfx_pkg;

   // Default table depth and the fixed field widths.
   localparam int SFX_DEPTH = 1024;
   localparam int SIZE_W    = 11;
   localparam int KEY_W     = 12;
   localparam int DELTA_W   = 2;
   localparam int SUM_W     = 16;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   // Register byte address of size_in_use.
   localparam logic [ADDR_W-1:0] REG_SIZE_ADDR = 2'd0;

   // Operation codes of an input word.
   typedef enum logic [0:0] {
      OP_ADD   = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;
      logic step;
      logic clear;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic done;
      logic is_query;
      logic out_busy;
   } status_type;

endpackage

// ===== src/sfx_ram.sv =====
module sfx_ram
   import sfx_pkg::*;
#(
   parameter int WIDTH = SUM_W,
   parameter int DEPTH = SFX_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/sfx_ctrl.sv =====
module sfx_ctrl
   import sfx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.step = 1'b1;
            if (status.done) begin
               if (!status.is_query) begin
                  state_in = ST_IDLE;
               end else if (!status.out_busy) begin
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sfx_dp.sv =====
module sfx_dp
   import sfx_pkg::*;
#(
   parameter int DEPTH = SFX_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  cmd_type                   cmd,
   output status_type                status,
   input  logic [SIZE_W-1:0]         size_in_use,
   input  logic                      req_op,
   input  logic signed [KEY_W-1:0]   req_key,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SUM_W-1:0]   rsp_suffix_sum
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = $clog2(DEPTH + 1);
   localparam int CW = (PW + 1 > KEY_W + 1) ? PW + 1 : KEY_W + 1;

   logic [CW-1:0]      n_c;
   logic [CW-1:0]      size_c;
   logic [CW-1:0]      depth_c;
   logic [CW-1:0]      key_pos;
   logic [CW-1:0]      start_pos;
   logic [CW-1:0]      p_ff, p_in;
   logic [CW-1:0]      p_minus;
   logic [CW-1:0]      p_next;
   logic               op_ff, op_in;
   logic [DELTA_W-1:0] delta_ff, delta_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      wp_ff, wp_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               out_valid_ff, out_valid_in;
   logic [SUM_W-1:0]   out_sum_ff, out_sum_in;
   logic               is_query;
   logic               more;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [SUM_W-1:0]   rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [SUM_W-1:0]   wr_data;
   logic [SUM_W-1:0]   delta_ext;

   // Effective size: size_in_use held within one and the depth.
   assign size_c  = CW'(size_in_use);
   assign depth_c = CW'(DEPTH);
   assign n_c = (size_c == '0) ? CW'(1) : ((size_c > depth_c) ? depth_c : size_c);

   // Start position from the key. A negative add key yields position zero,
   // which ends the walk at once; a negative query key starts at one.
   assign key_pos = CW'(req_key[KEY_W-1:0]) + CW'(1);
   always_comb begin
      if (req_op == OP_QUERY) begin
         start_pos = req_key[KEY_W-1] ? CW'(1) : key_pos;
      end else if (req_key[KEY_W-1]) begin
         start_pos = '0;
      end else begin
         start_pos = (key_pos > n_c) ? n_c : key_pos;
      end
   end

   // Walk step: adds clear the lowest set bit, queries add it.
   assign is_query = (op_ff == OP_QUERY);
   assign p_minus  = p_ff - CW'(1);
   assign p_next   = is_query ? (p_ff + (p_ff & (~p_ff + CW'(1)))) : (p_ff & p_minus);
   assign more     = is_query ? (p_ff <= n_c) : (p_ff != '0);

   assign rd_en   = cmd.step && more;
   assign rd_addr = p_minus[AW-1:0];

   // Walk registers.
   always_comb begin
      p_in     = p_ff;
      op_in    = op_ff;
      delta_in = delta_ff;
      wp_in    = wp_ff;
      acc_in   = acc_ff;
      pend_in  = rd_en;
      if (cmd.start) begin
         p_in     = start_pos;
         op_in    = req_op;
         delta_in = req_delta;
         acc_in   = '0;
         pend_in  = 1'b0;
      end else if (rd_en) begin
         p_in  = p_next;
         wp_in = rd_addr;
      end
      if (pend_ff && is_query) begin
         acc_in = acc_ff + rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         p_ff    <= '0;
         op_ff   <= OP_ADD;
      end else begin
         pend_ff <= pend_in;
         p_ff    <= p_in;
         op_ff   <= op_in;
      end
      delta_ff <= delta_in;
      wp_ff    <= wp_in;
      acc_ff   <= acc_in;
   end

   // Cell write: zero during the clearing pass, else the read-modify-write of an add.
   assign delta_ext = {{(SUM_W - DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = wp_ff;
      wr_data = rd_data + delta_ext;
      if (cmd.clear) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = '0;
      end else if (pend_ff && !is_query) begin
         wr_en = 1'b1;
      end
   end

   // Clearing pass counter.
   assign clr_in = cmd.clear ? clr_ff + AW'(1) : clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Output register, so a waiting result does not block the walk.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_sum_in   = out_sum_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         out_sum_in   = acc_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_sum_ff <= out_sum_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_suffix_sum = out_sum_ff;

   assign status.clr_last = (clr_ff == AW'(DEPTH - 1));
   assign status.done     = !more && !pend_ff;
   assign status.is_query = is_query;
   assign status.out_busy = out_valid_ff && !rsp_ready;

   sfx_ram #(
      .WIDTH(SUM_W),
      .DEPTH(DEPTH)
   ) u_cells (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

endmodule

// ===== src/suffix_count_fenwick_table.sv =====
// Suffix-count Fenwick table: a binary indexed tree walked in reverse.
// The req channel takes one word of op, key and delta. An add word adds
// delta to the cells on the downward walk from position key+1 (clamped to
// the size in use, dropped when key is negative) and gives no result. A
// query word sums the cells on the upward walk from key+1 and returns the
// suffix sum on the rsp channel; a negative key returns the full total.
// The APB port holds size_in_use at address 0.
// An item is accepted when the block is idle, so the next word waits
// until the walk of the last one is through. An add that visits k cells
// reads each cell and writes it back with delta added; an ignored add
// ends its walk at once. A query that visits k cells sums them and loads
// the result into the output register. k is at most log2(DEPTH) + 1, the
// walk making one read of the cell memory per visited cell, while writes
// go through its separate write port.
// After reset a clearing pass writes zero into all DEPTH cells, one per
// cycle; no item is accepted during the pass, while register writes are
// taken. A result waits in the output register while rsp_ready is low; the
// next item may be accepted then, and a query that finishes meanwhile
// holds until the register is free.
module suffix_count_fenwick_table
   import sfx_pkg::*;
#(
   parameter int DEPTH = SFX_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_op,
   input  logic signed [KEY_W-1:0]   req_key,
   input  logic signed [DELTA_W-1:0] req_delta,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [SUM_W-1:0]   rsp_suffix_sum,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [ADDR_W-1:0]         paddr,
   input  logic [DATA_W-1:0]         pwdata,
   output logic [DATA_W-1:0]         prdata,
   output logic                      pready
);

   logic [SIZE_W-1:0] size_ff, size_in;
   logic              csr_wr;
   cmd_type           cmd;
   status_type        status;

   // Configuration register.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr == REG_SIZE_ADDR);
   assign size_in = csr_wr ? pwdata[SIZE_W-1:0] : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   assign prdata = (paddr == REG_SIZE_ADDR) ? DATA_W'(size_ff) : '0;

   sfx_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   sfx_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .size_in_use   (size_ff),
      .req_op        (req_op),
      .req_key       (req_key),
      .req_delta     (req_delta),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_suffix_sum(rsp_suffix_sum)
   );

endmodule

// ===== sim/suffix_count_fenwick_table_tb.sv =====
module suffix_count_fenwick_table_tb;
   import sfx_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles an add may still be walking after the last result has come.
   localparam int SETTLE_CYCLES = 24;
   localparam int RANDOM_PER_PHASE = 65;

   typedef struct {
      op_type                    op;
      logic signed [KEY_W-1:0]   key;
      logic signed [DELTA_W-1:0] delta;
   } fen_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_op = 1'b0;
   logic signed [KEY_W-1:0]   req_key = '0;
   logic signed [DELTA_W-1:0] req_delta = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [SUM_W-1:0]   rsp_suffix_sum;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [ADDR_W-1:0]         paddr = '0;
   logic [DATA_W-1:0]         pwdata = '0;
   logic [DATA_W-1:0]         prdata;
   logic                      pready;

   // Stimulus bookkeeping and the mirror of the cell store.
   fen_word_type       pending_words[$];
   logic [SUM_W-1:0]   sums_due[$];
   logic [SUM_W-1:0]   cell_mirror [1:SFX_DEPTH];
   logic [SIZE_W-1:0]  size_shadow = SIZE_RESET;
   int                 words_queued = 0;
   int                 words_accepted = 0;
   int                 error_count = 0;
   bit                 req_gaps_on = 1'b1;
   bit                 rsp_stalls_on = 1'b1;
   int                 gap_left = 0;
   int                 stall_left = 0;

   suffix_count_fenwick_table u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_key        (req_key),
      .req_delta      (req_delta),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_suffix_sum (rsp_suffix_sum),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Size in use saturated to the positions the store really has.
   function automatic int table_span();
      int n;
      n = size_shadow;
      if (n < 1) n = 1;
      if (n > SFX_DEPTH) n = SFX_DEPTH;
      return n;
   endfunction

   // Downward walk: clear the lowest set bit after each visited cell.
   function automatic void add_to_mirror(logic signed [KEY_W-1:0] key,
                                         logic signed [DELTA_W-1:0] delta);
      int pos;
      int p;
      int d;
      pos = int'(key) + 1;
      d = int'(delta);
      if (pos < 1) return;
      p = (pos > table_span()) ? table_span() : pos;
      while (p != 0) begin
         cell_mirror[p] = cell_mirror[p] + d[SUM_W-1:0];
         p = p & (p - 1);
      end
   endfunction

   // Upward walk: add the lowest set bit while inside the size in use.
   function automatic logic [SUM_W-1:0] suffix_total(logic signed [KEY_W-1:0] key);
      int pos;
      int p;
      logic [SUM_W-1:0] acc;
      pos = int'(key) + 1;
      p = (pos < 1) ? 1 : pos;
      acc = '0;
      while (p <= table_span()) begin
         acc = acc + cell_mirror[p];
         p = p + (p & (~p + 1));
      end
      return acc;
   endfunction

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Random word with keys mostly inside the size in use, plus edge keys.
   function automatic fen_word_type make_word(int n);
      fen_word_type w;
      int r;
      int k;
      r = $urandom_range(0, 99);
      if (r < 70) k = $urandom_range(0, n - 1);
      else if (r < 80) k = -int'($urandom_range(1, 2048));
      else if (r < 88) k = $urandom_range(n, 2047);
      else if (r < 94) begin
         case ($urandom_range(0, 5))
            0: k = -2048;
            1: k = 2047;
            2: k = -1;
            3: k = 0;
            4: k = n - 1;
            default: k = n;
         endcase
      end else k = $urandom_range(0, 4095);
      w.op = ($urandom_range(0, 1) != 0) ? OP_QUERY : OP_ADD;
      w.key = k[KEY_W-1:0];
      k = $urandom_range(0, 3);
      w.delta = k[DELTA_W-1:0];
      return w;
   endfunction

   // Request driver: presents the next pending word after its gap.
   always @(posedge clock) begin
      fen_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            req_valid <= 1'b1;
            req_op <= w.op;
            req_key <= w.key;
            req_delta <= w.delta;
            gap_left = req_gaps_on ? pick_gap() : 0;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (rsp_stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 2);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: check a finished result first, then predict the accepted word.
   always @(posedge clock) begin
      logic [SUM_W-1:0] want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (sums_due.size() == 0) begin
               $display("%0t: unexpected suffix_sum word %0d, nothing pending",
                        $time, rsp_suffix_sum);
               error_count++;
            end else begin
               want = sums_due.pop_front();
               if (rsp_suffix_sum !== want) begin
                  $display("%0t: suffix_sum mismatch, expected %0d, got %0d",
                           $time, $signed(want), rsp_suffix_sum);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            words_accepted++;
            if (req_op == OP_QUERY) sums_due.insert(sums_due.size(), suffix_total(req_key));
            else add_to_mirror(req_key, req_delta);
         end
      end
   end

   task automatic queue_word(op_type op, int k, int d);
      fen_word_type w;
      w.op = op;
      w.key = k[KEY_W-1:0];
      w.delta = d[DELTA_W-1:0];
      pending_words.insert(pending_words.size(), w);
      words_queued++;
   endtask

   // Hold the sender until every word is in and every result is out.
   task automatic wait_drained();
      while (words_accepted != words_queued || sums_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_size_readback();
      logic [DATA_W-1:0] got;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= REG_SIZE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got[SIZE_W-1:0] !== size_shadow) begin
         $display("%0t: size_in_use readback mismatch, expected %0d, got %0d",
                  $time, size_shadow, got[SIZE_W-1:0]);
         error_count++;
      end
   endtask

   task automatic program_size(logic [SIZE_W-1:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= REG_SIZE_ADDR;
      pwdata <= DATA_W'(val);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      size_shadow = val;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      check_size_readback();
   endtask

   // Main sequence: reset, directed words, then random phases per size.
   initial begin
      int size_plan[10];
      size_plan = '{0, 1, 2047, 7, 300, 1025, 2, 1024, 513, 1024};
      for (int i = 1; i <= SFX_DEPTH; i++) cell_mirror[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset value of the size register, then directed words at full size.
      check_size_readback();
      queue_word(OP_QUERY, 0, 0);
      queue_word(OP_ADD, -1, 1);
      queue_word(OP_ADD, -2048, 1);
      queue_word(OP_ADD, 0, 1);
      queue_word(OP_ADD, 1023, -1);
      queue_word(OP_ADD, 2047, 1);
      queue_word(OP_ADD, 1023, -2);
      queue_word(OP_ADD, 511, 1);
      queue_word(OP_ADD, 500, 0);
      queue_word(OP_ADD, 1500, -2);
      queue_word(OP_QUERY, -1, 0);
      queue_word(OP_QUERY, -2048, 1);
      queue_word(OP_QUERY, -2, -2);
      queue_word(OP_QUERY, 0, -1);
      queue_word(OP_QUERY, 1, 0);
      queue_word(OP_QUERY, 511, 0);
      queue_word(OP_QUERY, 512, 0);
      queue_word(OP_QUERY, 1023, 1);
      queue_word(OP_QUERY, 1024, 0);
      queue_word(OP_QUERY, 2047, -2);
      wait_drained();

      // Random phases; cells above a shrunk size keep their counts.
      for (int i = 0; i < 10; i++) begin
         program_size(size_plan[i][SIZE_W-1:0]);
         req_gaps_on = (i % 3 != 1);
         rsp_stalls_on = (i % 3 != 2);
         for (int j = 0; j < RANDOM_PER_PHASE; j++) begin
            pending_words.insert(pending_words.size(), make_word(table_span()));
            words_queued++;
         end
         wait_drained();
      end

      if (error_count == 0) $display("suffix_count_fenwick_table regression: pass");
      else $display("suffix_count_fenwick_table regression: fail");
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5000000;
      $display("suffix_count_fenwick_table regression: fail");
      $finish;
   end

endmodule
